FILE: src/mjdct_pkg.sv
package mjdct_pkg;

  localparam int DAY_BITS      = 17;
  localparam int FRACTION_BITS = 32;
  localparam int STAGES        = 6;

  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DOM_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int TENTH_W  = 4;

  localparam int IN_FIELDS_W  = DAY_BITS + FRACTION_BITS;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = YEAR_W + MONTH_W + DOM_W + HOUR_W + MINUTE_W + SECOND_W
                                + TENTH_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // Date path. Every constant division is floor(n*M >> S) with M = ceil(2^S/D),
  // S = width(n) + clog2(D), which is exact over the whole numerator range.
  localparam longint unsigned W_OFS  = 64'd2131139;   // 4*(2400000+1) - 7468865
  localparam longint unsigned N1_MAX = 4 * ((64'd1 << DAY_BITS) - 1) + W_OFS;
  localparam int              N1_W   = $clog2(N1_MAX + 1);
  localparam longint unsigned D1     = 64'd146097;
  localparam int              S1     = N1_W + $clog2(D1);
  localparam longint unsigned M1     = ((64'd1 << S1) + D1 - 1) / D1;
  localparam int              M1_W   = $clog2(M1 + 1);
  localparam longint unsigned W_MAX  = N1_MAX / D1;
  localparam int              W_W    = $clog2(W_MAX + 1);

  localparam longint unsigned B_OFS  = 64'd2401526;   // 2400001 + 1 + 1524
  localparam longint unsigned B_MAX  = (64'd1 << DAY_BITS) - 1 + B_OFS + W_MAX;
  localparam int              B_W    = $clog2(B_MAX + 1);

  localparam longint unsigned C_OFS  = 64'd2442;
  localparam longint unsigned N2_MAX = 20 * B_MAX - C_OFS;
  localparam int              N2_W   = $clog2(N2_MAX + 1);
  localparam longint unsigned D2     = 64'd7305;
  localparam int              S2     = N2_W + $clog2(D2);
  localparam longint unsigned M2     = ((64'd1 << S2) + D2 - 1) / D2;
  localparam int              M2_W   = $clog2(M2 + 1);
  localparam longint unsigned C_MAX  = N2_MAX / D2;
  localparam int              C_W    = $clog2(C_MAX + 1);
  localparam int              DM_W   = C_W + 11;      // c * 1461

  localparam int              G_W    = 9;              // b - d stays below 490
  localparam longint unsigned D3     = 64'd306001;
  localparam int              S3     = G_W + $clog2(D3);
  localparam longint unsigned M3     = (((64'd1 << S3) * 10000) + D3 - 1) / D3;
  localparam int              M3_W   = $clog2(M3 + 1);
  localparam int              E_W    = 4;

  localparam int YEAR_BASE_WRAP = 4715;
  localparam int YEAR_BASE      = 4716;
  localparam int MONTH_WRAP     = 14;

  // Time path: deciseconds of the day, then split by 10, 600 and 36000.
  localparam longint unsigned T_MUL   = 64'd864000;
  localparam int              T_MUL_W = 20;
  localparam int              PT_W    = FRACTION_BITS + T_MUL_W;
  localparam int              T_W     = 20;
  localparam longint unsigned T_MAX   = 64'd863999;

  localparam longint unsigned RS10_D  = 64'd10;
  localparam int              RS10    = T_W + $clog2(RS10_D);
  localparam longint unsigned RM10    = ((64'd1 << RS10) + RS10_D - 1) / RS10_D;
  localparam int              RM10_W  = $clog2(RM10 + 1);
  localparam int              Q10_W   = $clog2(T_MAX / RS10_D + 1);

  localparam longint unsigned RS600_D = 64'd600;
  localparam int              RS600   = T_W + $clog2(RS600_D);
  localparam longint unsigned RM600   = ((64'd1 << RS600) + RS600_D - 1) / RS600_D;
  localparam int              RM600_W = $clog2(RM600 + 1);
  localparam int              Q600_W  = $clog2(T_MAX / RS600_D + 1);

  localparam longint unsigned RS36K_D = 64'd36000;
  localparam int              RS36K   = T_W + $clog2(RS36K_D);
  localparam longint unsigned RM36K   = ((64'd1 << RS36K) + RS36K_D - 1) / RS36K_D;
  localparam int              RM36K_W = $clog2(RM36K + 1);
  localparam int              Q36K_W  = $clog2(T_MAX / RS36K_D + 1);

  typedef struct packed {
    logic [STAGES-1:0] en;
  } pipe_ctl_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   day_of_month;
  } date_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic [TENTH_W-1:0]  tenth_second;
  } tod_t;

  // floor(30.6001 * e)
  function automatic logic [G_W-1:0] month_start(input logic [E_W-1:0] e);
    logic [G_W-1:0] f;
    unique case (e)
      4'd0:    f = G_W'(0);
      4'd1:    f = G_W'(30);
      4'd2:    f = G_W'(61);
      4'd3:    f = G_W'(91);
      4'd4:    f = G_W'(122);
      4'd5:    f = G_W'(153);
      4'd6:    f = G_W'(183);
      4'd7:    f = G_W'(214);
      4'd8:    f = G_W'(244);
      4'd9:    f = G_W'(275);
      4'd10:   f = G_W'(306);
      4'd11:   f = G_W'(336);
      4'd12:   f = G_W'(367);
      4'd13:   f = G_W'(397);
      4'd14:   f = G_W'(428);
      default: f = G_W'(459);
    endcase
    return f;
  endfunction

endpackage

FILE: src/mjdct_ctrl.sv
module mjdct_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output mjdct_pkg::pipe_ctl_t  ctl
);

  logic [mjdct_pkg::STAGES-1:0] vld_r;
  logic [mjdct_pkg::STAGES-1:0] vld_nxt;
  logic [mjdct_pkg::STAGES-1:0] en;

  // a stage loads when it is empty or its contents move on
  always_comb begin
    en[mjdct_pkg::STAGES-1] = !vld_r[mjdct_pkg::STAGES-1] || out_tready;
    for (int k = mjdct_pkg::STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_tvalid;
    end
    for (int k = 1; k < mjdct_pkg::STAGES; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctl.en     = en;
  assign in_tready  = en[0];
  assign out_tvalid = vld_r[mjdct_pkg::STAGES-1];

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (vld_r == '0))
    else $error("pipeline not empty after reset");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ((&vld_r) && !out_tready) |-> !in_tready)
    else $error("input taken while pipeline full and stalled");

  a_held_kept: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld_r & ~en) != '0) |=> ((vld_r & $past(vld_r & ~en)) == $past(vld_r & ~en)))
    else $error("stalled stage lost its transaction");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted transaction did not enter first stage");

endmodule

FILE: src/mjdct_date.sv
module mjdct_date (
  input  logic                              clk,
  input  mjdct_pkg::pipe_ctl_t              ctl,
  input  logic [mjdct_pkg::DAY_BITS-1:0]    mjd_day,
  output mjdct_pkg::date_t                  date
);

  localparam int P1_W = mjdct_pkg::N1_W + mjdct_pkg::M1_W;
  localparam int P2_W = mjdct_pkg::N2_W + mjdct_pkg::M2_W;
  localparam int P3_W = mjdct_pkg::G_W + mjdct_pkg::M3_W;

  logic [mjdct_pkg::N1_W-1:0]     n1;
  logic [P1_W-1:0]                p1_nxt, p1_r;
  logic [mjdct_pkg::DAY_BITS-1:0] day0_r;

  logic [mjdct_pkg::W_W-1:0]      w;
  logic [mjdct_pkg::B_W-1:0]      b1_nxt, b1_r;

  logic [mjdct_pkg::N2_W-1:0]     n2;
  logic [P2_W-1:0]                p2_nxt, p2_r;
  logic [mjdct_pkg::B_W-1:0]      b2_r;

  logic [mjdct_pkg::C_W-1:0]      c;
  logic [mjdct_pkg::DM_W-1:0]     dm;
  logic [mjdct_pkg::B_W-1:0]      g_full;
  logic [mjdct_pkg::C_W-1:0]      c3_r, c4_r;
  logic [mjdct_pkg::G_W-1:0]      g3_r, g4_r;

  logic [P3_W-1:0]                p3_nxt, p3_r;

  logic [mjdct_pkg::E_W-1:0]      e;
  logic [mjdct_pkg::G_W-1:0]      f;
  logic [mjdct_pkg::C_W-1:0]      yr;
  mjdct_pkg::date_t               date_nxt, date_r;

  // stage 0: w numerator times reciprocal of 146097
  assign n1     = mjdct_pkg::N1_W'({mjd_day, 2'b00}) + mjdct_pkg::N1_W'(mjdct_pkg::W_OFS);
  assign p1_nxt = P1_W'(n1) * P1_W'(mjdct_pkg::M1);

  // stage 1: b = z + 1 + w - w/4 + 1524
  assign w      = p1_r[mjdct_pkg::S1 +: mjdct_pkg::W_W];
  assign b1_nxt = mjdct_pkg::B_W'(day0_r) + mjdct_pkg::B_W'(mjdct_pkg::B_OFS)
                  + mjdct_pkg::B_W'(w) - mjdct_pkg::B_W'(w >> 2);

  // stage 2: c numerator times reciprocal of 7305
  assign n2     = mjdct_pkg::N2_W'(b1_r) * mjdct_pkg::N2_W'(20)
                  - mjdct_pkg::N2_W'(mjdct_pkg::C_OFS);
  assign p2_nxt = P2_W'(n2) * P2_W'(mjdct_pkg::M2);

  // stage 3: c, d = 1461c/4, g = b - d
  assign c      = p2_r[mjdct_pkg::S2 +: mjdct_pkg::C_W];
  assign dm     = mjdct_pkg::DM_W'(c) * mjdct_pkg::DM_W'(1461);
  assign g_full = b2_r - mjdct_pkg::B_W'(dm >> 2);

  // stage 4: e = 10000g/306001 as one reciprocal product
  assign p3_nxt = P3_W'(g3_r) * P3_W'(mjdct_pkg::M3);

  // stage 5: month, day, year
  assign e = p3_r[mjdct_pkg::S3 +: mjdct_pkg::E_W];
  assign f = mjdct_pkg::month_start(e);

  always_comb begin
    date_nxt.day_of_month = mjdct_pkg::DOM_W'(g4_r - f);
    if (e >= mjdct_pkg::E_W'(mjdct_pkg::MONTH_WRAP)) begin
      date_nxt.month = mjdct_pkg::MONTH_W'(e - mjdct_pkg::E_W'(13));
      yr             = c4_r - mjdct_pkg::C_W'(mjdct_pkg::YEAR_BASE_WRAP);
    end else begin
      date_nxt.month = mjdct_pkg::MONTH_W'(e - mjdct_pkg::E_W'(1));
      yr             = c4_r - mjdct_pkg::C_W'(mjdct_pkg::YEAR_BASE);
    end
    date_nxt.year = mjdct_pkg::YEAR_W'(yr);
  end

  // b travels with p2 in a stage-2 copy
  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      p1_r   <= p1_nxt;
      day0_r <= mjd_day;
    end
    if (ctl.en[1]) begin
      b1_r <= b1_nxt;
    end
    if (ctl.en[2]) begin
      p2_r <= p2_nxt;
      b2_r <= b1_r;
    end
    if (ctl.en[3]) begin
      c3_r <= c;
      g3_r <= mjdct_pkg::G_W'(g_full);
    end
    if (ctl.en[4]) begin
      p3_r <= p3_nxt;
      c4_r <= c3_r;
      g4_r <= g3_r;
    end
    if (ctl.en[5]) begin
      date_r <= date_nxt;
    end
  end

  assign date = date_r;

endmodule

FILE: src/mjdct_time.sv
module mjdct_time (
  input  logic                                clk,
  input  mjdct_pkg::pipe_ctl_t                ctl,
  input  logic [mjdct_pkg::FRACTION_BITS-1:0] day_fraction,
  output mjdct_pkg::tod_t                     tod
);

  localparam int P10_W  = mjdct_pkg::T_W + mjdct_pkg::RM10_W;
  localparam int P600_W = mjdct_pkg::T_W + mjdct_pkg::RM600_W;
  localparam int P36K_W = mjdct_pkg::T_W + mjdct_pkg::RM36K_W;

  logic [mjdct_pkg::PT_W-1:0]   pt_r;
  logic [mjdct_pkg::T_W-1:0]    t1_r, t2_r;
  logic [P10_W-1:0]             p10_r;
  logic [P600_W-1:0]            p600_r;
  logic [P36K_W-1:0]            p36k_r;
  logic [mjdct_pkg::Q10_W-1:0]  q10;
  logic [mjdct_pkg::Q600_W-1:0] q600;
  logic [mjdct_pkg::Q36K_W-1:0] q36k;
  mjdct_pkg::tod_t              tod_nxt, tod3_r, tod4_r, tod5_r;

  // quotients t/10, t/600, t/36000 from registered reciprocal products
  assign q10  = p10_r[mjdct_pkg::RS10 +: mjdct_pkg::Q10_W];
  assign q600 = p600_r[mjdct_pkg::RS600 +: mjdct_pkg::Q600_W];
  assign q36k = p36k_r[mjdct_pkg::RS36K +: mjdct_pkg::Q36K_W];

  always_comb begin
    tod_nxt.tenth_second = mjdct_pkg::TENTH_W'(
      t2_r - mjdct_pkg::T_W'(q10) * mjdct_pkg::T_W'(10));
    tod_nxt.second = mjdct_pkg::SECOND_W'(
      q10 - mjdct_pkg::Q10_W'(q600) * mjdct_pkg::Q10_W'(60));
    tod_nxt.minute = mjdct_pkg::MINUTE_W'(
      q600 - mjdct_pkg::Q600_W'(q36k) * mjdct_pkg::Q600_W'(60));
    tod_nxt.hour = mjdct_pkg::HOUR_W'(q36k);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      pt_r <= mjdct_pkg::PT_W'(day_fraction) * mjdct_pkg::PT_W'(mjdct_pkg::T_MUL);
    end
    if (ctl.en[1]) begin
      t1_r <= pt_r[mjdct_pkg::FRACTION_BITS +: mjdct_pkg::T_W];
    end
    if (ctl.en[2]) begin
      p10_r  <= P10_W'(t1_r) * P10_W'(mjdct_pkg::RM10);
      p600_r <= P600_W'(t1_r) * P600_W'(mjdct_pkg::RM600);
      p36k_r <= P36K_W'(t1_r) * P36K_W'(mjdct_pkg::RM36K);
      t2_r   <= t1_r;
    end
    if (ctl.en[3]) begin
      tod3_r <= tod_nxt;
    end
    if (ctl.en[4]) begin
      tod4_r <= tod3_r;
    end
    if (ctl.en[5]) begin
      tod5_r <= tod4_r;
    end
  end

  assign tod = tod5_r;

endmodule

FILE: src/mjd_to_calendar_timestamp.sv
// MJD to Gregorian calendar timestamp.
// Input channel (in_*): one transaction carries a Modified Julian Date as a
// whole day number plus a binary fraction of a day. Output channel (out_*):
// one transaction per input with year, month, day, hour, minute, second and
// truncated tenth of a second.
// Pipeline: six register stages between acceptance and out_tvalid.
// Throughput: one transaction per cycle while out_tready is not held low.
// The six register stages follow the date path: three chained constant
// divisions, each a reciprocal multiply with a register after it; the time
// path runs beside it.
// Reset (rst_n low, synchronous) empties every stage; nothing in flight is
// kept. When the receiver holds out_tready low, the result stays on out_tdata
// and the stages behind it keep filling bubbles; in_tready drops only once
// every stage holds a transaction.
module mjd_to_calendar_timestamp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // mjd_day [16:0], day_fraction [48:17], zero pad above
  input  logic [mjdct_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // year [11:0], month [15:12], day_of_month [20:16], hour [25:21],
  // minute [31:26], second [37:32], tenth_second [41:38], zero pad above
  output logic [mjdct_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  mjdct_pkg::pipe_ctl_t ctl;
  mjdct_pkg::date_t     date;
  mjdct_pkg::tod_t      tod;

  mjdct_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl)
  );

  mjdct_date u_date (
    .clk     (clk),
    .ctl     (ctl),
    .mjd_day (in_tdata[mjdct_pkg::DAY_BITS-1:0]),
    .date    (date)
  );

  mjdct_time u_time (
    .clk          (clk),
    .ctl          (ctl),
    .day_fraction (in_tdata[mjdct_pkg::DAY_BITS +: mjdct_pkg::FRACTION_BITS]),
    .tod          (tod)
  );

  assign out_tdata = {{mjdct_pkg::OUT_PAD_W{1'b0}},
                      tod.tenth_second, tod.second, tod.minute, tod.hour,
                      date.day_of_month, date.month, date.year};

endmodule
